/* rtl/udprc_pkg.sv */
// Shared types and constants for the UDP receive checker.
// No dependencies; used by every module of the block.
package udprc_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int UDP_PROTO    = 17;
    localparam int PORT_SLOTS   = 8;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 64;
    localparam int SLOT_W       = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PORTS_LOW  = 1'b0,
        CFG_PORTS_HIGH = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        VERDICT_DELIVERED    = 3'd0,
        VERDICT_TOO_SHORT    = 3'd1,
        VERDICT_BAD_LENGTH   = 3'd2,
        VERDICT_BAD_CHECKSUM = 3'd3,
        VERDICT_NO_BINDING   = 3'd4
    } verdict_t;

    // One finished datagram, as handed from the front to the back.
    typedef struct packed {
        logic        too_short;
        logic        bad_length;
        logic [31:0] sum;
        logic [15:0] length;
        logic [7:0]  pending;
        logic [15:0] checksum;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } dgram_t;

    typedef logic [PORT_SLOTS-1:0][15:0] port_table_t;

endpackage

/* rtl/udprc_front.sv */
// Front end: accepts datagram bytes, parses the header and accumulates the
// ones-complement sum. Pushes one record per datagram. Uses udprc_pkg.
module udprc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [31:0]         source_ip,
    input  logic [31:0]         destination_ip,
    input  logic                q_ready,
    output logic                q_push,
    output udprc_pkg::dgram_t   q_data
);

    logic [15:0] count_reg, count_next;
    logic [31:0] sum_reg, sum_next;
    logic [7:0]  pend_reg, pend_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] csum_reg, csum_next;

    logic        accept;
    logic        is_header;
    logic        sum_en;
    logic [7:0]  byte_val;
    logic [18:0] ip_sum;

    assign in_ready  = q_ready;
    assign accept    = in_valid && q_ready;
    assign is_header = (count_reg[15:3] == 13'd0);
    assign sum_en    = is_header || (count_reg < len_reg);
    // checksum field is summed as zero
    assign byte_val  = (is_header && (count_reg[2:1] == 2'b11)) ? 8'h00 : data_byte;
    assign ip_sum    = {3'b000, source_ip[31:16]} + {3'b000, source_ip[15:0]}
                     + {3'b000, destination_ip[31:16]} + {3'b000, destination_ip[15:0]}
                     + 19'(udprc_pkg::UDP_PROTO);

    always_comb
    begin
        sport_next = sport_reg;
        dport_next = dport_reg;
        len_next   = len_reg;
        csum_next  = csum_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        if (is_header)
        begin
            case (count_reg[2:0])
                3'd0:    sport_next = {data_byte, 8'h00};
                3'd1:    sport_next = {sport_reg[15:8], data_byte};
                3'd2:    dport_next = {data_byte, 8'h00};
                3'd3:    dport_next = {dport_reg[15:8], data_byte};
                3'd4:    len_next   = {data_byte, 8'h00};
                3'd5:    len_next   = {len_reg[15:8], data_byte};
                3'd6:    csum_next  = {data_byte, 8'h00};
                default: csum_next  = {csum_reg[15:8], data_byte};
            endcase
        end
        if (count_reg == 16'd0)
        begin
            sum_next = 32'(ip_sum);
        end
        else if (sum_en && count_reg[0])
        begin
            sum_next = sum_reg + {16'h0000, pend_reg, byte_val};
        end
        if (sum_en && !count_reg[0])
        begin
            pend_next = byte_val;
        end
        count_next = (&count_reg) ? count_reg : count_reg + 16'd1;
    end

    assign q_push = accept && last_byte;

    always_comb
    begin
        q_data.too_short   = count_next < 16'(udprc_pkg::HEADER_BYTES);
        q_data.bad_length  = (len_next < 16'(udprc_pkg::HEADER_BYTES)) || (len_next > count_next);
        q_data.sum         = sum_next;
        q_data.length      = len_next;
        q_data.pending     = pend_next;
        q_data.checksum    = csum_next;
        q_data.source_port = sport_next;
        q_data.dest_port   = dport_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            pend_reg  <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            len_reg   <= '0;
            csum_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                pend_reg  <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
                len_reg   <= '0;
                csum_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                pend_reg  <= pend_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
                len_reg   <= len_next;
                csum_reg  <= csum_next;
            end
        end
    end

endmodule

/* rtl/udprc_queue.sv */
// Small FIFO of finished datagram records between front and back.
// Uses udprc_pkg for the record type.
module udprc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  udprc_pkg::dgram_t   push_data,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output udprc_pkg::dgram_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    udprc_pkg::dgram_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign not_full  = (fill_reg != CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/udprc_back.sv */
// Back end: finishes the checksum, decides the verdict and looks up the
// destination port. Two stages with a registered output. Uses udprc_pkg.
module udprc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  udprc_pkg::dgram_t       q_head,
    output logic                    q_pop,
    input  udprc_pkg::port_table_t  bound_ports,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              verdict,
    output logic [15:0]             source_port,
    output logic [15:0]             destination_port,
    output logic [15:0]             payload_length,
    output logic [2:0]              slot_index
);

    logic                s1_valid_reg;
    udprc_pkg::dgram_t   s1_reg;
    udprc_pkg::dgram_t   s1_load;
    logic                s1_free;
    logic                out_load;
    logic [31:0]         pad_word;

    logic                out_valid_reg;
    udprc_pkg::verdict_t verdict_reg, verdict_next;
    logic [15:0]         sport_reg, sport_next;
    logic [15:0]         dport_reg, dport_next;
    logic [15:0]         plen_reg, plen_next;
    logic [udprc_pkg::SLOT_W-1:0] slot_reg, slot_next;

    logic [16:0]         fold1;
    logic [15:0]         fold2;
    logic [15:0]         calc;
    logic                csum_bad;
    logic                found;
    logic [udprc_pkg::SLOT_W-1:0] found_slot;

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free  = !s1_valid_reg || out_load;
    assign q_pop    = q_valid && s1_free;
    assign pad_word = q_head.length[0] ? {16'h0000, q_head.pending, 8'h00} : 32'd0;

    always_comb
    begin
        s1_load     = q_head;
        s1_load.sum = q_head.sum + {16'h0000, q_head.length} + pad_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_reg <= s1_load;
        end
    end

    assign fold1 = {1'b0, s1_reg.sum[15:0]} + {1'b0, s1_reg.sum[31:16]};
    assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
    assign calc  = (fold2 == 16'hFFFF) ? 16'hFFFF : ~fold2;
    assign csum_bad = (s1_reg.checksum != 16'h0000) && (calc != s1_reg.checksum);

    always_comb
    begin
        found      = 1'b0;
        found_slot = '0;
        for (int i = udprc_pkg::PORT_SLOTS - 1; i >= 0; i--)
        begin
            if ((bound_ports[i] != 16'h0000) && (bound_ports[i] == s1_reg.dest_port))
            begin
                found      = 1'b1;
                found_slot = udprc_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        verdict_next = udprc_pkg::VERDICT_TOO_SHORT;
        sport_next   = '0;
        dport_next   = '0;
        plen_next    = '0;
        slot_next    = '0;
        if (!s1_reg.too_short)
        begin
            sport_next = s1_reg.source_port;
            dport_next = s1_reg.dest_port;
            if (s1_reg.bad_length)
            begin
                verdict_next = udprc_pkg::VERDICT_BAD_LENGTH;
            end
            else
            begin
                plen_next = s1_reg.length - 16'(udprc_pkg::HEADER_BYTES);
                if (csum_bad)
                begin
                    verdict_next = udprc_pkg::VERDICT_BAD_CHECKSUM;
                end
                else if (found)
                begin
                    verdict_next = udprc_pkg::VERDICT_DELIVERED;
                    slot_next    = found_slot;
                end
                else
                begin
                    verdict_next = udprc_pkg::VERDICT_NO_BINDING;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            verdict_reg <= verdict_next;
            sport_reg   <= sport_next;
            dport_reg   <= dport_next;
            plen_reg    <= plen_next;
            slot_reg    <= slot_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign verdict          = verdict_reg;
    assign source_port      = sport_reg;
    assign destination_port = dport_reg;
    assign payload_length   = plen_reg;
    assign slot_index       = slot_reg;

endmodule

/* rtl/udp_receive_checker.sv */
// UDP receive checker: one datagram byte per cycle, one verdict per datagram.
// Throughput: one byte per cycle. The record of the last byte goes from the
// queue to the checksum stage, then to the output register, which raises out_valid
// when the output is free. Input stalls only while the record queue is full.
// Reset clears the parser state, the queue, the pipeline valids and both
// bound port registers; no clearing pass is needed.
// Depends on udprc_pkg, udprc_front, udprc_queue, udprc_back.
module udp_receive_checker #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [udprc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [udprc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    input  logic [31:0]                       source_ip,
    input  logic [31:0]                       destination_ip,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        verdict,
    output logic [15:0]                       source_port,
    output logic [15:0]                       destination_port,
    output logic [15:0]                       payload_length,
    output logic [2:0]                        slot_index
);

    logic [udprc_pkg::CFG_DATA_W-1:0] ports_low_reg;
    logic [udprc_pkg::CFG_DATA_W-1:0] ports_high_reg;
    udprc_pkg::port_table_t           bound_ports;

    logic              q_push;
    logic              q_not_full;
    logic              q_pop;
    logic              q_not_empty;
    udprc_pkg::dgram_t q_in;
    udprc_pkg::dgram_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ports_low_reg  <= '0;
            ports_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (udprc_pkg::cfg_index_t'(cfg_index))
                udprc_pkg::CFG_PORTS_LOW:  ports_low_reg  <= cfg_data;
                udprc_pkg::CFG_PORTS_HIGH: ports_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign bound_ports = {ports_high_reg, ports_low_reg};

    udprc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .source_ip      (source_ip),
        .destination_ip (destination_ip),
        .q_ready        (q_not_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    udprc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    udprc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_not_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .bound_ports      (bound_ports),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .verdict          (verdict),
        .source_port      (source_port),
        .destination_port (destination_port),
        .payload_length   (payload_length),
        .slot_index       (slot_index)
    );

endmodule

/* rtl/udprc_checker.sv */
// Port-level assertions for udp_receive_checker, attached by bind.
// Uses udprc_pkg for the verdict codes.
module udprc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  verdict,
    input  logic [15:0] source_port,
    input  logic [15:0] destination_port,
    input  logic [15:0] payload_length,
    input  logic [2:0]  slot_index
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict)
            && $stable(destination_port) && $stable(slot_index))
        else $error("result changed while stalled");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict <= udprc_pkg::VERDICT_NO_BINDING)
        else $error("verdict code out of range");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == udprc_pkg::VERDICT_TOO_SHORT |->
            source_port == 16'd0 && destination_port == 16'd0
            && payload_length == 16'd0 && slot_index == 3'd0)
        else $error("too-short item carries nonzero fields");

    a_slot_only_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict != udprc_pkg::VERDICT_DELIVERED |-> slot_index == 3'd0)
        else $error("slot index set on undelivered item");

    a_badlen_plen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == udprc_pkg::VERDICT_BAD_LENGTH |-> payload_length == 16'd0)
        else $error("payload length set on bad-length item");

endmodule

bind udp_receive_checker udprc_checker u_udprc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .verdict          (verdict),
    .source_port      (source_port),
    .destination_port (destination_port),
    .payload_length   (payload_length),
    .slot_index       (slot_index)
);

/* sim/tb.sv */
// Testbench for udp_receive_checker: feeds UDP datagrams byte by byte and
// checks each verdict against an in-bench model of the parser and checksum.
// Depends on udprc_pkg and the udp_receive_checker RTL.
module tb;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN       = 16;

    typedef enum int { CK_GOOD, CK_NONE, CK_BAD, CK_ZERO } ck_mode_t;

    typedef struct packed {
        udprc_pkg::verdict_t          code;
        logic [15:0]                  sport;
        logic [15:0]                  dport;
        logic [15:0]                  plen;
        logic [udprc_pkg::SLOT_W-1:0] slot;
    } verdict_rec_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_write;
    logic [udprc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [udprc_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic [7:0]                        data_byte;
    logic                              last_byte;
    logic [31:0]                       source_ip;
    logic [31:0]                       destination_ip;
    logic                              out_valid;
    logic                              out_ready;
    logic [2:0]                        verdict;
    logic [15:0]                       source_port;
    logic [15:0]                       destination_port;
    logic [15:0]                       payload_length;
    logic [2:0]                        slot_index;

    logic [7:0]  dg[$];
    logic [15:0] bound[udprc_pkg::PORT_SLOTS];
    bit          calm;
    int          total_bytes;
    int          total_dgrams;
    int          tables_written;
    int          stall_cycles;

    udp_receive_checker DUT (.*);

    function automatic logic [15:0] fold16(input logic [31:0] x);
        logic [31:0] s;
        s = x;
        while (s[31:16] != 16'h0000)
            s = 32'(s[15:0]) + 32'(s[31:16]);
        return s[15:0];
    endfunction

    class verdict_board;
        logic [15:0]  ports[udprc_pkg::PORT_SLOTS];
        logic [15:0]  count;
        logic [31:0]  acc;
        logic [7:0]   pend;
        logic [15:0]  hsp;
        logic [15:0]  hdp;
        logic [15:0]  hlen;
        logic [15:0]  hck;
        verdict_rec_t verdicts_due[$];
        int           errors;
        int           tally[5];

        function new();
            foreach (ports[i])
                ports[i] = 16'h0000;
            foreach (tally[i])
                tally[i] = 0;
            errors = 0;
            clear();
        endfunction

        function void clear();
            count = 16'h0000;
            acc   = 32'h0;
            pend  = 8'h00;
            hsp   = 16'h0000;
            hdp   = 16'h0000;
            hlen  = 16'h0000;
            hck   = 16'h0000;
        endfunction

        function void set_port_reg(udprc_pkg::cfg_index_t idx,
                                   logic [udprc_pkg::CFG_DATA_W-1:0] value);
            for (int i = 0; i < 4; i++)
                ports[(idx == udprc_pkg::CFG_PORTS_HIGH ? 4 : 0) + i] = value[16*i +: 16];
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void absorb_byte(logic [7:0] b, logic last, logic [31:0] sip,
                                  logic [31:0] dip);
            logic [15:0]  pos;
            logic [7:0]   v;
            logic [31:0]  s;
            logic [15:0]  calc;
            verdict_rec_t r;
            pos = count;
            if (pos == 16'h0000)
                acc = 32'(sip[31:16]) + 32'(sip[15:0]) + 32'(dip[31:16])
                    + 32'(dip[15:0]) + 32'(udprc_pkg::UDP_PROTO);
            case (pos)
                16'd0: hsp = {b, 8'h00};
                16'd1: hsp[7:0] = b;
                16'd2: hdp = {b, 8'h00};
                16'd3: hdp[7:0] = b;
                16'd4: hlen = {b, 8'h00};
                16'd5: hlen[7:0] = b;
                16'd6: hck = {b, 8'h00};
                16'd7: hck[7:0] = b;
                default: ;
            endcase
            if (pos < 16'(udprc_pkg::HEADER_BYTES) || pos < hlen)
            begin
                v = (pos == 16'd6 || pos == 16'd7) ? 8'h00 : b;
                if (pos[0] == 1'b0)
                    pend = v;
                else
                    acc += {16'h0000, pend, v};
            end
            if (count != 16'hFFFF)
                count++;
            if (!last)
                return;
            r = '0;
            if (count < 16'(udprc_pkg::HEADER_BYTES))
            begin
                r.code = udprc_pkg::VERDICT_TOO_SHORT;
            end
            else
            begin
                r.sport = hsp;
                r.dport = hdp;
                if (hlen < 16'(udprc_pkg::HEADER_BYTES) || hlen > count)
                begin
                    r.code = udprc_pkg::VERDICT_BAD_LENGTH;
                end
                else
                begin
                    r.plen = hlen - 16'(udprc_pkg::HEADER_BYTES);
                    s = acc + 32'(hlen);
                    if (hlen[0])
                        s += {16'h0000, pend, 8'h00};
                    calc = ~fold16(s);
                    if (calc == 16'h0000)
                        calc = 16'hFFFF;
                    if (hck != 16'h0000 && calc != hck)
                    begin
                        r.code = udprc_pkg::VERDICT_BAD_CHECKSUM;
                    end
                    else
                    begin
                        r.code = udprc_pkg::VERDICT_NO_BINDING;
                        for (int i = udprc_pkg::PORT_SLOTS - 1; i >= 0; i--)
                            if (ports[i] != 16'h0000 && ports[i] == hdp)
                            begin
                                r.code = udprc_pkg::VERDICT_DELIVERED;
                                r.slot = udprc_pkg::SLOT_W'(i);
                            end
                    end
                end
            end
            verdicts_due.push_back(r);
            clear();
        endfunction

        function void report(string what, verdict_rec_t want, verdict_rec_t got);
            errors++;
            if (errors <= 10)
            begin
                $display("%s: want v=%0d sp=%h dp=%h len=%0d slot=%0d",
                         what, want.code, want.sport, want.dport, want.plen, want.slot);
                $display("    got v=%0d sp=%h dp=%h len=%0d slot=%0d",
                         got.code, got.sport, got.dport, got.plen, got.slot);
            end
        endfunction

        function void check_verdict(logic [2:0] v, logic [15:0] sp, logic [15:0] dp,
                                    logic [15:0] pl, logic [2:0] sl);
            verdict_rec_t got;
            verdict_rec_t want;
            got = {udprc_pkg::verdict_t'(v), sp, dp, pl, sl};
            if (verdicts_due.size() == 0)
            begin
                report("unexpected verdict", '0, got);
                return;
            end
            want = verdicts_due.pop_front();
            if (got.code != want.code || got.sport != want.sport || got.dport != want.dport
                    || got.plen != want.plen || got.slot != want.slot)
                report("verdict mismatch", want, got);
            else
                tally[int'(want.code)]++;
        endfunction

        function void close_out();
            while (verdicts_due.size() != 0)
                report("missing verdict", verdicts_due.pop_front(), '0);
        endfunction
    endclass

    verdict_board sb;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] pseudo_sum(logic [31:0] sip, logic [31:0] dip, int len);
        logic [31:0] s;
        logic [7:0]  hi;
        logic [7:0]  lo;
        s = 32'(sip[31:16]) + 32'(sip[15:0]) + 32'(dip[31:16]) + 32'(dip[15:0])
          + 32'(udprc_pkg::UDP_PROTO) + 32'(len);
        for (int i = 0; i < len; i += 2)
        begin
            hi = (i == 6) ? 8'h00 : dg[i];
            lo = (i + 1 < len && i + 1 != 7) ? dg[i+1] : 8'h00;
            s += {16'h0000, hi, lo};
        end
        return s;
    endfunction

    task automatic make_dgram(input logic [15:0] sport, input logic [15:0] dport,
                              input int plen, input int extra, input ck_mode_t mode,
                              input logic [31:0] sip, input logic [31:0] dip);
        logic [15:0] len16;
        logic [15:0] good;
        logic [15:0] ck;
        logic [15:0] w;
        len16 = 16'(plen + udprc_pkg::HEADER_BYTES);
        dg.delete();
        dg.push_back(sport[15:8]);
        dg.push_back(sport[7:0]);
        dg.push_back(dport[15:8]);
        dg.push_back(dport[7:0]);
        dg.push_back(len16[15:8]);
        dg.push_back(len16[7:0]);
        dg.push_back(8'h00);
        dg.push_back(8'h00);
        repeat (plen + extra)
            dg.push_back(8'($urandom));
        // pick the first data word so the sum folds to all ones
        if (mode == CK_ZERO)
        begin
            dg[8] = 8'h00;
            dg[9] = 8'h00;
            w = 16'hFFFF - fold16(pseudo_sum(sip, dip, int'(len16)));
            dg[8] = w[15:8];
            dg[9] = w[7:0];
        end
        good = ~fold16(pseudo_sum(sip, dip, int'(len16)));
        if (good == 16'h0000)
            good = 16'hFFFF;
        case (mode)
            CK_NONE: ck = 16'h0000;
            CK_BAD:
            begin
                ck = good ^ 16'($urandom_range(1, 16'hFFFF));
                while (ck == 16'h0000)
                    ck = good ^ 16'($urandom_range(1, 16'hFFFF));
            end
            default: ck = good;
        endcase
        dg[6] = ck[15:8];
        dg[7] = ck[7:0];
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] sip,
                             input logic [31:0] dip);
        while (!calm && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        last_byte      <= last;
        source_ip      <= sip;
        destination_ip <= dip;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        sb.absorb_byte(b, last, sip, dip);
        @(posedge clk);
    endtask

    task automatic send_dgram(input logic [31:0] sip, input logic [31:0] dip);
        for (int i = 0; i < dg.size(); i++)
            send_byte(dg[i], i == dg.size() - 1, i == 0 ? sip : $urandom,
                      i == 0 ? dip : $urandom);
        total_bytes  += dg.size();
        total_dgrams++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);
    endtask

    task automatic write_ports(input logic [63:0] lo, input logic [63:0] hi);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= udprc_pkg::CFG_PORTS_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= udprc_pkg::CFG_PORTS_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_port_reg(udprc_pkg::CFG_PORTS_LOW, lo);
        sb.set_port_reg(udprc_pkg::CFG_PORTS_HIGH, hi);
        for (int i = 0; i < 4; i++)
        begin
            bound[i]     = lo[16*i +: 16];
            bound[i + 4] = hi[16*i +: 16];
        end
        tables_written++;
    endtask

    task automatic random_dgram();
        int          kind;
        int          plen;
        int          extra;
        int          pick;
        ck_mode_t    mode;
        logic [15:0] dport;
        logic [15:0] len16;
        logic [31:0] sip;
        logic [31:0] dip;
        sip   = $urandom;
        dip   = $urandom;
        kind  = $urandom_range(0, 99);
        plen  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        pick  = $urandom_range(0, 9);
        dport = (pick < 7) ? bound[$urandom_range(0, udprc_pkg::PORT_SLOTS - 1)]
              : (pick == 7) ? 16'h0000 : 16'($urandom);
        if (kind < 8)
        begin
            dg.delete();
            repeat ($urandom_range(1, udprc_pkg::HEADER_BYTES - 1))
                dg.push_back(8'($urandom));
        end
        else
        begin
            mode = (kind < 16) ? CK_GOOD : (kind < 26) ? CK_BAD : (kind < 34) ? CK_NONE
                 : (kind < 40) ? CK_ZERO : CK_GOOD;
            if (mode == CK_ZERO && plen < 2)
                plen = 2;
            make_dgram(16'($urandom), dport, plen, extra, mode, sip, dip);
            if (kind < 16)
            begin
                len16 = (kind < 12) ? 16'($urandom_range(0, udprc_pkg::HEADER_BYTES - 1))
                                    : 16'(dg.size() + $urandom_range(1, 300));
                dg[4] = len16[15:8];
                dg[5] = len16[7:0];
            end
        end
        send_dgram(sip, dip);
    endtask

    task automatic random_phase(input int min_bytes, input int min_dgrams);
        int start_bytes;
        int start_dgrams;
        start_bytes  = total_bytes;
        start_dgrams = total_dgrams;
        while (total_bytes - start_bytes < min_bytes || total_dgrams - start_dgrams < min_dgrams)
            random_dgram();
    endtask

    function automatic logic [63:0] random_table(input int zero_pct);
        logic [63:0] t;
        for (int i = 0; i < 4; i++)
            t[16*i +: 16] = ($urandom_range(0, 99) < zero_pct) ? 16'h0000 : 16'($urandom);
        return t;
    endfunction

    // output side: random back-pressure and verdict checks
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= calm || ($urandom_range(0, 99) >= 23);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_verdict(verdict, source_port, destination_port, payload_length,
                                 slot_index);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("[udp_receive_checker] ERROR");
        $finish;
    end

    initial
    begin
        logic [63:0] lo;
        logic [15:0] v;
        sb             = new();
        calm           = 1'b0;
        total_bytes    = 0;
        total_dgrams   = 0;
        tables_written = 0;
        foreach (bound[i])
            bound[i] = 16'h0000;
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= udprc_pkg::CFG_PORTS_LOW;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        data_byte      <= 8'h00;
        last_byte      <= 1'b0;
        source_ip      <= 32'h0;
        destination_ip <= 32'h0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset table: everything empty
        dg.delete();
        dg.push_back(8'hA5);
        send_dgram($urandom, $urandom);
        make_dgram(16'h0000, 16'h0000, 0, 0, CK_GOOD, 32'h0, 32'h0);
        send_dgram(32'h0, 32'h0);

        // slot 0=1, 1=ffff, 2=1234, 3 empty, 4=7, 5=8000, 6 empty, 7=1234
        write_ports(64'h0000_1234_FFFF_0001, 64'h1234_0000_8000_0007);
        dg.delete();
        repeat (7)
            dg.push_back(8'hFF);
        send_dgram(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        make_dgram(16'hFFFF, 16'hFFFF, 0, 0, CK_GOOD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_dgram(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        make_dgram(16'h4321, 16'h1234, 3, 2, CK_GOOD, 32'h0, 32'h0);
        send_dgram(32'h0, 32'h0);
        lo = {$urandom, $urandom};
        make_dgram(16'($urandom), 16'h8000, 2, 0, CK_ZERO, lo[63:32], lo[31:0]);
        send_dgram(lo[63:32], lo[31:0]);
        make_dgram(16'($urandom), 16'h0007, 1, 0, CK_NONE, 32'h0A00_0001, 32'h0A00_0002);
        send_dgram(32'h0A00_0001, 32'h0A00_0002);
        make_dgram(16'($urandom), 16'h0001, 0, 0, CK_BAD, 32'h0A00_0001, 32'h0A00_0002);
        send_dgram(32'h0A00_0001, 32'h0A00_0002);
        make_dgram(16'h8000, 16'h0001, 0, 0, CK_GOOD, 32'h0, 32'h0);
        dg[4] = 8'h00;
        dg[5] = 8'h03;
        send_dgram(32'h0, 32'h0);
        make_dgram(16'h0001, 16'h0001, 1, 0, CK_GOOD, 32'h0, 32'h0);
        dg[5] = 8'd12;
        send_dgram(32'h0, 32'h0);
        make_dgram(16'h1111, 16'h0000, 0, 0, CK_GOOD, 32'h0, 32'h0);
        send_dgram(32'h0, 32'h0);

        write_ports('1, '1);
        random_phase(70, 3);
        write_ports(random_table(25), random_table(25));
        calm = 1'b1;
        random_phase(70, 3);
        calm = 1'b0;
        write_ports(random_table(0), 64'h0);
        random_phase(70, 3);
        v = 16'($urandom_range(1, 16'hFFFF));
        write_ports({v, 16'($urandom), v, 16'h0000}, {16'h0000, v, 16'($urandom), v});
        random_phase(70, 3);

        wait_idle();
        sb.close_out();
        $display("covered %0d datagrams, %0d bytes, %0d port tables",
                 total_dgrams, total_bytes, tables_written);
        $display("verdicts: delivered %0d, too short %0d, bad length %0d, bad checksum %0d",
                 sb.tally[int'(udprc_pkg::VERDICT_DELIVERED)],
                 sb.tally[int'(udprc_pkg::VERDICT_TOO_SHORT)],
                 sb.tally[int'(udprc_pkg::VERDICT_BAD_LENGTH)],
                 sb.tally[int'(udprc_pkg::VERDICT_BAD_CHECKSUM)],
                 ", unbound %0d", sb.tally[int'(udprc_pkg::VERDICT_NO_BINDING)]);
        if (sb.errors == 0)
            $display("[udp_receive_checker] OK");
        else
            $display("[udp_receive_checker] ERROR");
        $finish;
    end
endmodule

/* filelist.f */
rtl/udprc_pkg.sv
rtl/udprc_front.sv
rtl/udprc_queue.sv
rtl/udprc_back.sv
rtl/udp_receive_checker.sv
rtl/udprc_checker.sv
sim/tb.sv
